[src/tslc_pkg.sv]
// Package with the types and constants shared by the seen-type cache.
`default_nettype none
package tslc_pkg;

  // Cache geometry. BUCKETS must be a power of two: the bucket is the low hash bits.
  localparam int BUCKETS   = 256;
  localparam int WAYS      = 4;
  localparam int KEY_WIDTH = 64;

  localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Request type codes.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef key_t [WAYS-1:0]      row_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [WAY_W-1:0]     way_t;

  // Input item.
  typedef struct packed {
    logic        req_type;
    logic [63:0] type_key;
    logic [31:0] type_hash;
  } req_t;

  // Result item.
  typedef struct packed {
    logic must_emit;
    logic was_hit;
  } rsp_t;

  // Outcome of one bucket lookup.
  typedef struct packed {
    logic hit;
    way_t hit_way;
  } lookup_t;

endpackage
`default_nettype wire

[src/tslc_bucket_update.sv]
// Tag compare over one bucket and the move-to-front update of its ways.
`default_nettype none
module tslc_bucket_update
  import tslc_pkg::*;
(
  input  wire row_t row,
  input  wire key_t key,
  output lookup_t   lookup,
  output row_t      new_row
);

  way_t last_way;

  // Find the most recent way that holds the key; the lowest index wins.
  always_comb begin
    lookup.hit     = 1'b0;
    lookup.hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row[w] == key) begin
        lookup.hit     = 1'b1;
        lookup.hit_way = way_t'(w);
      end
    end
  end

  // On a miss the whole bucket shifts and the oldest way drops out.
  assign last_way = lookup.hit ? lookup.hit_way : way_t'(WAYS - 1);

  // Ways up to the shift point move down by one; the key goes in front.
  always_comb begin
    new_row[0] = key;
    for (int w = 1; w < WAYS; w++) begin
      if (way_t'(w) <= last_way) begin
        new_row[w] = row[w-1];
      end else begin
        new_row[w] = row[w];
      end
    end
  end

endmodule
`default_nettype wire

[src/type_seen_lru_cache.sv]
// Top level of the seen-type cache: bucket memory, lookup stage and result register.
//
// Usage:
//   The req channel carries one item per valid/ready handshake: a lookup of
//   type_key in the bucket picked by the low bits of type_hash, or a clear of
//   the whole cache. The rsp channel returns exactly one item per request:
//   must_emit is set when the key was missing and has just been recorded,
//   was_hit when it was found. Zero-key lookups and clears return both low.
//   The item passes the lookup stage register and then the result register
//   before rsp_valid rises. Throughput is one item per cycle while the
//   receiver takes results, set by the single bucket read-modify-write: a
//   bucket row is read from the memory in the accept cycle and written
//   back when the item leaves the lookup stage, and a following item to the
//   same bucket takes the written row from a forwarding register.
//   A flip-flop valid bit per bucket marks rows that hold data; reset and a
//   clear request drop all of them at once, so no clearing sweep runs
//   and the block takes items right after reset.
//   When the receiver stalls, the result waits in the output register, one
//   more item waits in the lookup stage, and req_ready then falls.
`default_nettype none
module type_seen_lru_cache
  import tslc_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  input  wire       req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire       rsp_ready,
  output rsp_t      rsp
);

  // Bucket memory and per-bucket valid bits.
  row_t             mem [BUCKETS];
  row_t             rd_row;
  logic [BUCKETS-1:0] row_valid;

  // Lookup stage.
  logic    s1_valid;
  req_t    s1_req;
  logic    s1_row_ok;
  logic    s1_use_fwd;
  row_t    fwd_row;

  logic    req_fire;
  logic    s1_fire;
  idx_t    in_idx;
  idx_t    s1_idx;
  key_t    s1_key;
  logic    s1_write;
  logic    s1_clear;
  row_t    cur_row;
  row_t    new_row;
  lookup_t lookup;

  assign in_idx   = req.type_hash[IDX_W-1:0];
  assign s1_idx   = s1_req.type_hash[IDX_W-1:0];
  assign s1_key   = s1_req.type_key[KEY_WIDTH-1:0];
  assign s1_clear = (s1_req.req_type == REQ_CLEAR);
  assign s1_write = s1_fire && !s1_clear && (s1_key != '0);

  // The stage completes when the output register is free or being emptied.
  assign s1_fire   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_fire;
  assign req_fire  = req_valid && req_ready;

  // Row seen by the item in the lookup stage.
  always_comb begin
    if (s1_use_fwd) begin
      cur_row = fwd_row;
    end else if (s1_row_ok) begin
      cur_row = rd_row;
    end else begin
      cur_row = '0;
    end
  end

  tslc_bucket_update u_update (
    .row     (cur_row),
    .key     (s1_key),
    .lookup  (lookup),
    .new_row (new_row)
  );

  // Memory write-back and registered read.
  always_ff @(posedge clk) begin
    if (s1_write) begin
      mem[s1_idx] <= new_row;
    end
    if (req_fire) begin
      rd_row <= mem[in_idx];
    end
  end

  // Bucket valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (s1_fire && s1_clear) begin
      row_valid <= '0;
    end else if (s1_write) begin
      row_valid[s1_idx] <= 1'b1;
    end
  end

  // Lookup stage control; a write in the same cycle overrides the memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_req <= req;
      if (s1_fire && s1_clear) begin
        s1_row_ok  <= 1'b0;
        s1_use_fwd <= 1'b0;
      end else if (s1_write && (s1_idx == in_idx)) begin
        s1_row_ok  <= 1'b1;
        s1_use_fwd <= 1'b1;
      end else begin
        s1_row_ok  <= row_valid[in_idx];
        s1_use_fwd <= 1'b0;
      end
      fwd_row <= new_row;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp.was_hit   <= s1_write && lookup.hit;
      rsp.must_emit <= s1_write && !lookup.hit;
    end
  end

endmodule
`default_nettype wire
